[rtl/mahf_pkg.sv]
`timescale 1ns / 1ps

package mahf_pkg;

    localparam int BUFFER_BYTES_DEF = 65536;
    localparam int TAG_WINDOW_DEF   = 1024;

    localparam logic [7:0]  SYNC_BYTE = 8'hFF;
    localparam logic [7:0]  SYNC_MASK = 8'hE0;
    localparam logic [31:0] TAG_XING  = 32'h5869_6E67;
    localparam logic [31:0] TAG_INFO  = 32'h496E_666F;

    localparam logic [1:0]  VER_25     = 2'd0;
    localparam logic [1:0]  VER_RSVD   = 2'd1;
    localparam logic [1:0]  VER_2      = 2'd2;
    localparam logic [1:0]  VER_1      = 2'd3;
    localparam logic [1:0]  LAYER_RSVD = 2'd0;
    localparam logic [1:0]  RATE_RSVD  = 2'd3;
    localparam logic [1:0]  MODE_MONO  = 2'd3;
    localparam logic [3:0]  BRI_FREE   = 4'd0;
    localparam logic [3:0]  BRI_BAD    = 4'd15;

    localparam logic [10:0] SPF_MPEG1  = 11'd1152;
    localparam logic [10:0] SPF_MPEG2  = 11'd576;
    localparam logic [3:0]  TAG_BYTES  = 4'd8;
    localparam int          FLAG_BIT   = 32;

    typedef struct packed {
        logic        valid;
        logic [8:0]  bitrate;
        logic [15:0] sample_rate;
        logic [1:0]  channels;
        logic [10:0] spf;
    } t_hdr_info;

    typedef struct packed {
        logic        seen;
        logic [31:0] frames;
    } t_tag_stat;

    function automatic logic [8:0] kbps_lookup(input logic [3:0] idx);
        logic [8:0] v;
        case (idx)
            4'd1:    v = 9'd32;
            4'd2:    v = 9'd40;
            4'd3:    v = 9'd48;
            4'd4:    v = 9'd56;
            4'd5:    v = 9'd64;
            4'd6:    v = 9'd80;
            4'd7:    v = 9'd96;
            4'd8:    v = 9'd112;
            4'd9:    v = 9'd128;
            4'd10:   v = 9'd160;
            4'd11:   v = 9'd192;
            4'd12:   v = 9'd224;
            4'd13:   v = 9'd256;
            4'd14:   v = 9'd320;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] hz_lookup(input logic [1:0] idx);
        logic [15:0] v;
        case (idx)
            2'd0:    v = 16'd44100;
            2'd1:    v = 16'd48000;
            2'd2:    v = 16'd32000;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/mahf_hdr_decode.sv]
`timescale 1ns / 1ps

module mahf_hdr_decode (
    input  logic [31:0]         i_win,
    output mahf_pkg::t_hdr_info o_hdr
);
    import mahf_pkg::*;

    logic [7:0]  w_b0, w_b1, w_b2, w_b3;
    logic [1:0]  w_ver, w_lay, w_rti;
    logic [3:0]  w_bri;
    logic [15:0] w_hz;

    assign w_b0  = i_win[31:24];
    assign w_b1  = i_win[23:16];
    assign w_b2  = i_win[15:8];
    assign w_b3  = i_win[7:0];
    assign w_ver = w_b1[4:3];
    assign w_lay = w_b1[2:1];
    assign w_bri = w_b2[7:4];
    assign w_rti = w_b2[3:2];
    assign w_hz  = hz_lookup(w_rti);

    always_comb begin
        o_hdr.valid = (w_b0 == SYNC_BYTE) && ((w_b1 & SYNC_MASK) == SYNC_MASK)
                   && (w_ver != VER_RSVD) && (w_lay != LAYER_RSVD)
                   && (w_bri != BRI_FREE) && (w_bri != BRI_BAD)
                   && (w_rti != RATE_RSVD);
        o_hdr.bitrate = kbps_lookup(w_bri);
        case (w_ver)
            VER_2:   o_hdr.sample_rate = w_hz >> 1;
            VER_25:  o_hdr.sample_rate = w_hz >> 2;
            default: o_hdr.sample_rate = w_hz;
        endcase
        o_hdr.channels = (w_b3[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
        o_hdr.spf      = (w_ver == VER_1) ? SPF_MPEG1 : SPF_MPEG2;
    end

endmodule

[rtl/mahf_tag_scan.sv]
`timescale 1ns / 1ps

module mahf_tag_scan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_clear,
    input  logic                i_scan,
    input  logic [31:0]         i_tag,
    input  logic [31:0]         i_win,
    input  logic [7:0]          i_byte,
    output mahf_pkg::t_tag_stat o_stat
);
    import mahf_pkg::*;

    logic        r_seen, n_seen;
    logic [3:0]  r_cnt, n_cnt;
    logic [63:0] r_words, n_words;

    always_comb begin
        n_seen  = r_seen;
        n_cnt   = r_cnt;
        n_words = r_words;
        if (i_scan) begin
            // capture starts on the byte after the tag's last letter
            if (r_seen && (r_cnt < TAG_BYTES)) begin
                n_words = {r_words[55:0], i_byte};
                n_cnt   = r_cnt + 4'd1;
            end
            if (!r_seen && (i_win == i_tag)) begin
                n_seen = 1'b1;
            end
        end
    end

    // status reflects the state after the current item
    always_comb begin
        o_stat.seen   = n_seen;
        o_stat.frames = ((n_cnt == TAG_BYTES) && n_words[FLAG_BIT]) ? n_words[31:0] : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= 1'b0;
            r_cnt   <= 4'd0;
            r_words <= 64'd0;
        end else if (i_step) begin
            if (i_clear) begin
                r_seen  <= 1'b0;
                r_cnt   <= 4'd0;
                r_words <= 64'd0;
            end else begin
                r_seen  <= n_seen;
                r_cnt   <= n_cnt;
                r_words <= n_words;
            end
        end
    end

endmodule

[rtl/mpeg_audio_header_finder.sv]
`timescale 1ns / 1ps
// Channel       Dir  Handshake                     Payload
// s_axis        in   s_axis_tvalid/s_axis_tready   tdata: data_byte; tlast: last
// m_axis        out  m_axis_tvalid/m_axis_tready   tuser: found; tdata: result fields
// cfg           in   i_cfg_we                      i_cfg_wdata: start_offset
//
// One byte per cycle unless a last byte waits on a stalled result: an input
// register feeds the header decode and tag compare, and the result register is
// loaded from the input register on the byte marked last.
// Reset (synchronous, active low) clears start_offset and the parse and valid state.
// A stalled result holds only a last byte; other bytes keep flowing.

module mpeg_audio_header_finder #(
    parameter int BUFFER_BYTES = mahf_pkg::BUFFER_BYTES_DEF,
    parameter int TAG_WINDOW   = mahf_pkg::TAG_WINDOW_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic        s_axis_tlast,  // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,  // [15:0] header_position, [24:16] bitrate_kbps,
                                       // [40:25] sample_rate_hz, [42:41] channel_count,
                                       // [53:43] samples_per_frame, [85:54] frame_count,
                                       // [87:86] zero
    output logic        m_axis_tuser,  // found
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata    // start_offset
);
    import mahf_pkg::*;

    localparam int HW = $clog2(BUFFER_BYTES);
    localparam int PW = HW + 1;

    logic [15:0]   r_start_offset;

    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    logic          r_in_last;

    logic [PW-1:0] r_pos, n_pos;
    logic [23:0]   r_recent, n_recent;
    logic          r_hdr_seen, n_hdr_seen;
    logic [HW-1:0] r_hdr_start, n_hdr_start;
    logic [8:0]    r_bitrate, n_bitrate;
    logic [15:0]   r_hz, n_hz;
    logic [1:0]    r_ch, n_ch;
    logic [10:0]   r_spf, n_spf;

    logic          r_out_valid;
    logic          r_out_found;
    logic [87:0]   r_out_data;

    logic          w_take;
    logic          w_in_buf;
    logic          w_scan;
    logic          w_try;
    logic [31:0]   w_win;
    logic [PW-1:0] w_dist;
    logic [31:0]   w_frames;
    t_hdr_info     w_hdr;
    t_tag_stat     w_xing, w_info;

    assign w_take        = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_take;

    assign w_win    = {r_recent, r_in_byte};
    assign w_in_buf = 32'(r_pos) < 32'(BUFFER_BYTES);
    assign w_dist   = r_pos - PW'(r_hdr_start);
    assign w_scan   = w_in_buf && r_hdr_seen && (32'(w_dist) < 32'(TAG_WINDOW));
    assign w_try    = w_in_buf && !r_hdr_seen
                   && (32'(r_pos) >= (32'(r_start_offset) + 32'd3));

    mahf_hdr_decode u_decode (
        .i_win (w_win),
        .o_hdr (w_hdr)
    );

    mahf_tag_scan u_xing (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_take),
        .i_clear (r_in_last),
        .i_scan  (w_scan),
        .i_tag   (TAG_XING),
        .i_win   (w_win),
        .i_byte  (r_in_byte),
        .o_stat  (w_xing)
    );

    mahf_tag_scan u_info (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_take),
        .i_clear (r_in_last),
        .i_scan  (w_scan),
        .i_tag   (TAG_INFO),
        .i_win   (w_win),
        .i_byte  (r_in_byte),
        .o_stat  (w_info)
    );

    always_comb begin
        n_pos       = r_pos;
        n_recent    = r_recent;
        n_hdr_seen  = r_hdr_seen;
        n_hdr_start = r_hdr_start;
        n_bitrate   = r_bitrate;
        n_hz        = r_hz;
        n_ch        = r_ch;
        n_spf       = r_spf;
        if (w_in_buf) begin
            n_pos    = r_pos + PW'(1);
            n_recent = w_win[23:0];
        end
        if (w_try && w_hdr.valid) begin
            n_hdr_seen  = 1'b1;
            n_hdr_start = HW'(r_pos - PW'(3));
            n_bitrate   = w_hdr.bitrate;
            n_hz        = w_hdr.sample_rate;
            n_ch        = w_hdr.channels;
            n_spf       = w_hdr.spf;
        end
    end

    // Xing wins whenever seen, even with its flag clear
    always_comb begin
        if (w_xing.seen) begin
            w_frames = w_xing.frames;
        end else if (w_info.seen) begin
            w_frames = w_info.frames;
        end else begin
            w_frames = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_offset <= 16'd0;
        end else if (i_cfg_we) begin
            r_start_offset <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_recent    <= 24'd0;
            r_hdr_seen  <= 1'b0;
            r_hdr_start <= '0;
            r_bitrate   <= 9'd0;
            r_hz        <= 16'd0;
            r_ch        <= 2'd0;
            r_spf       <= 11'd0;
        end else if (w_take) begin
            if (r_in_last) begin
                // start a new buffer after the result
                r_pos       <= '0;
                r_recent    <= 24'd0;
                r_hdr_seen  <= 1'b0;
                r_hdr_start <= '0;
                r_bitrate   <= 9'd0;
                r_hz        <= 16'd0;
                r_ch        <= 2'd0;
                r_spf       <= 11'd0;
            end else begin
                r_pos       <= n_pos;
                r_recent    <= n_recent;
                r_hdr_seen  <= n_hdr_seen;
                r_hdr_start <= n_hdr_start;
                r_bitrate   <= n_bitrate;
                r_hz        <= n_hz;
                r_ch        <= n_ch;
                r_spf       <= n_spf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && r_in_last) begin
            r_out_found <= n_hdr_seen;
            if (n_hdr_seen) begin
                r_out_data <= {2'b00, w_frames, n_spf, n_ch, n_hz, n_bitrate,
                               16'(n_hdr_start)};
            end else begin
                r_out_data <= 88'd0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_found;
    assign m_axis_tdata  = r_out_data;

    a_no_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 88'd0))
        else $error("result without header carries nonzero fields");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_take && r_in_last))
        else $error("result appeared without a last byte");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pos) <= 32'(BUFFER_BYTES))
        else $error("byte position ran past the buffer size");

    a_hdr_behind_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_seen |-> ((32'(r_hdr_start) + 32'd3) < 32'(r_pos)))
        else $error("header start not behind the current position");

    a_stall_holds_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_last && m_axis_tvalid && !m_axis_tready) |-> !w_take)
        else $error("last byte consumed while result stalled");

endmodule

[verif/mahf_result_checker.sv]
`timescale 1ns / 1ps

module mahf_result_checker #(
    parameter int BUFFER_BYTES = mahf_pkg::BUFFER_BYTES_DEF,
    parameter int TAG_WINDOW   = mahf_pkg::TAG_WINDOW_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [87:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output int          o_mismatches,
    output int          o_results_due
);

    import mahf_pkg::*;

    typedef struct packed {
        logic        found;
        logic [15:0] position;
        logic [8:0]  kbps;
        logic [15:0] hz;
        logic [1:0]  channels;
        logic [10:0] spf;
        logic [31:0] frames;
    } t_summary;

    // Bitrate by index, index 0 in the low bits
    localparam logic [143:0] KBPS_ROM = {
        9'd0, 9'd320, 9'd256, 9'd224, 9'd192, 9'd160, 9'd128, 9'd112,
        9'd96, 9'd80, 9'd64, 9'd56, 9'd48, 9'd40, 9'd32, 9'd0
    };
    localparam logic [63:0] HZ_ROM = {16'd0, 16'd32000, 16'd48000, 16'd44100};

    t_summary    expected_summaries[$];

    logic [15:0] search_from;
    int unsigned byte_pos;
    logic [23:0] last_three;
    logic        hdr_seen;
    logic [15:0] hdr_pos;
    logic [8:0]  hdr_kbps;
    logic [15:0] hdr_hz;
    logic [1:0]  hdr_channels;
    logic [10:0] hdr_spf;
    logic        xing_hit;
    logic [3:0]  xing_len;
    logic [63:0] xing_bytes;
    logic        info_hit;
    logic [3:0]  info_len;
    logic [63:0] info_bytes;

    task automatic restart_buffer();
        byte_pos     = 0;
        last_three   = '0;
        hdr_seen     = 1'b0;
        hdr_pos      = '0;
        hdr_kbps     = '0;
        hdr_hz       = '0;
        hdr_channels = '0;
        hdr_spf      = '0;
        xing_hit     = 1'b0;
        xing_len     = '0;
        xing_bytes   = '0;
        info_hit     = 1'b0;
        info_len     = '0;
        info_bytes   = '0;
    endtask

    // Frame count only when flags and count both fit and flag bit 0 is set
    function automatic logic [31:0] tag_frame_count(input logic [3:0] len,
                                                    input logic [63:0] bytes);
        if (len < TAG_BYTES)
            return '0;
        if (!bytes[FLAG_BIT])
            return '0;
        return bytes[31:0];
    endfunction

    task automatic take_byte(input logic [7:0] value, input logic is_last);
        logic [31:0] win;
        logic [1:0]  ver;
        logic [1:0]  lay;
        logic [3:0]  bri;
        logic [1:0]  rti;
        logic [15:0] hz;
        t_summary    s;
        win = {last_three, value};
        if (byte_pos < BUFFER_BYTES) begin
            if (hdr_seen) begin
                if (byte_pos - hdr_pos < TAG_WINDOW) begin
                    if (xing_hit && xing_len < TAG_BYTES) begin
                        xing_bytes = {xing_bytes[55:0], value};
                        xing_len++;
                    end
                    if (info_hit && info_len < TAG_BYTES) begin
                        info_bytes = {info_bytes[55:0], value};
                        info_len++;
                    end
                    if (!xing_hit && win == TAG_XING && byte_pos - 3 >= hdr_pos)
                        xing_hit = 1'b1;
                    if (!info_hit && win == TAG_INFO && byte_pos - 3 >= hdr_pos)
                        info_hit = 1'b1;
                end
            end else if (byte_pos >= 3 && byte_pos - 3 >= search_from) begin
                ver = win[20:19];
                lay = win[18:17];
                bri = win[15:12];
                rti = win[11:10];
                if (win[31:24] == SYNC_BYTE && (win[23:16] & SYNC_MASK) == SYNC_MASK
                        && ver != VER_RSVD && lay != LAYER_RSVD && bri != BRI_FREE
                        && bri != BRI_BAD && rti != RATE_RSVD) begin
                    hz = HZ_ROM[rti * 16 +: 16];
                    if (ver == VER_2)
                        hz = hz / 2;
                    else if (ver == VER_25)
                        hz = hz / 4;
                    hdr_seen     = 1'b1;
                    hdr_pos      = 16'(byte_pos - 3);
                    hdr_kbps     = KBPS_ROM[bri * 9 +: 9];
                    hdr_hz       = hz;
                    hdr_channels = (win[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
                    hdr_spf      = (ver == VER_1) ? SPF_MPEG1 : SPF_MPEG2;
                end
            end
            last_three = win[23:0];
            byte_pos++;
        end
        if (is_last) begin
            s = '0;
            if (hdr_seen) begin
                s.found    = 1'b1;
                s.position = hdr_pos;
                s.kbps     = hdr_kbps;
                s.hz       = hdr_hz;
                s.channels = hdr_channels;
                s.spf      = hdr_spf;
                if (xing_hit)
                    s.frames = tag_frame_count(xing_len, xing_bytes);
                else if (info_hit)
                    s.frames = tag_frame_count(info_len, info_bytes);
            end
            expected_summaries.push_back(s);
            restart_buffer();
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            o_mismatches++;
        end
    endtask

    task automatic check_summary(input logic found, input logic [87:0] data);
        t_summary want;
        if (expected_summaries.size() == 0) begin
            $error("result with nothing expected: found %0d, header_position %0d",
                   found, data[15:0]);
            o_mismatches++;
        end else begin
            want = expected_summaries.pop_front();
            check_field("found", want.found, found);
            check_field("header_position", want.position, data[15:0]);
            check_field("bitrate_kbps", want.kbps, data[24:16]);
            check_field("sample_rate_hz", want.hz, data[40:25]);
            check_field("channel_count", want.channels, data[42:41]);
            check_field("samples_per_frame", want.spf, data[53:43]);
            check_field("frame_count", want.frames, data[85:54]);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_buffer();
            search_from = '0;
            expected_summaries.delete();
            o_mismatches  = 0;
            o_results_due = 0;
        end else begin
            if (i_cfg_we)
                search_from = i_cfg_wdata;
            if (m_axis_tvalid && m_axis_tready)
                check_summary(m_axis_tuser, m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                take_byte(s_axis_tdata, s_axis_tlast);
            o_results_due = expected_summaries.size();
        end
    end

endmodule

[verif/mpeg_audio_header_finder_tb.sv]
`timescale 1ns / 1ps

module mpeg_audio_header_finder_tb;

    import mahf_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 4;

    localparam int READY_ALWAYS = 0;
    localparam int READY_COIN   = 1;
    localparam int READY_SPARSE = 2;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    wire         s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [87:0] m_axis_tdata;
    wire         m_axis_tuser;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    int          mismatches;
    int          results_due;

    logic [7:0]  head_bytes[$];
    int          sent_bytes = 0;
    int          burst_left = 0;
    int          ready_mode = READY_ALWAYS;
    int          mode_left = 0;

    mpeg_audio_header_finder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    mahf_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_mismatches  (mismatches),
        .o_results_due (results_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: switch between always ready, coin flip and mostly stalled
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode = $urandom_range(READY_ALWAYS, READY_SPARSE);
            mode_left  = $urandom_range(16, 160);
        end else begin
            mode_left--;
        end
        case (ready_mode)
            READY_ALWAYS: m_axis_tready <= 1'b1;
            READY_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            default:      m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic send_byte(input logic [7:0] value, input logic is_last);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        if (burst_left > 0)
            burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= is_last;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_bytes++;
    endtask

    task automatic send_buffer();
        int n;
        if (head_bytes.size() == 0)
            head_bytes.push_back(8'($urandom));
        n = head_bytes.size();
        for (int k = 0; k < n; k++)
            send_byte(head_bytes[k], k == n - 1);
        head_bytes.delete();
    endtask

    // Hold the sender until every result is back and the block has settled
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_search_start(input logic [15:0] offset);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= offset;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic add_noise(input int count, input int ff_odds);
        for (int k = 0; k < count; k++) begin
            if (ff_odds != 0 && $urandom_range(1, ff_odds) == 1)
                head_bytes.push_back(8'hFF);
            else
                head_bytes.push_back(8'($urandom));
        end
    endtask

    task automatic add_word(input logic [31:0] w);
        head_bytes.push_back(w[31:24]);
        head_bytes.push_back(w[23:16]);
        head_bytes.push_back(w[15:8]);
        head_bytes.push_back(w[7:0]);
    endtask

    task automatic add_tag(input logic [31:0] name, input logic [31:0] flags,
                           input logic [31:0] count);
        add_word(name);
        add_word(flags);
        add_word(count);
    endtask

    task automatic add_header(input logic [1:0] ver, input logic [1:0] layer,
                              input logic [3:0] bri, input logic [1:0] rate,
                              input logic [1:0] mode);
        head_bytes.push_back(SYNC_BYTE);
        head_bytes.push_back({3'b111, ver, layer, 1'($urandom_range(0, 1))});
        head_bytes.push_back({bri, rate, 2'($urandom_range(0, 3))});
        head_bytes.push_back({mode, 6'($urandom_range(0, 63))});
    endtask

    task automatic add_valid_header();
        logic [1:0] ver;
        case ($urandom_range(0, 2))
            0:       ver = VER_25;
            1:       ver = VER_2;
            default: ver = VER_1;
        endcase
        add_header(ver, 2'($urandom_range(1, 3)), 4'($urandom_range(1, 14)),
                   2'($urandom_range(0, 2)), 2'($urandom_range(0, 3)));
    endtask

    // One field reserved or the sync broken
    task automatic add_broken_header();
        logic [1:0] lay;
        logic [3:0] bri;
        logic [1:0] rate;
        lay  = 2'($urandom_range(1, 3));
        bri  = 4'($urandom_range(1, 14));
        rate = 2'($urandom_range(0, 2));
        case ($urandom_range(0, 6))
            0: add_header(VER_RSVD, lay, bri, rate, 2'($urandom));
            1: add_header(VER_1, LAYER_RSVD, bri, rate, 2'($urandom));
            2: add_header(VER_2, lay, BRI_FREE, rate, 2'($urandom));
            3: add_header(VER_25, lay, BRI_BAD, rate, 2'($urandom));
            4: add_header(VER_1, lay, bri, RATE_RSVD, 2'($urandom));
            5: begin
                head_bytes.push_back(SYNC_BYTE);
                head_bytes.push_back({3'($urandom_range(0, 6)), 5'($urandom)});
                add_noise(2, 0);
            end
            default: begin
                head_bytes.push_back(8'($urandom_range(0, 254)));
                head_bytes.push_back(8'hFB);
                add_noise(2, 0);
            end
        endcase
    endtask

    task automatic add_random_tag(input logic [31:0] name);
        logic [31:0] flags;
        flags    = $urandom;
        flags[0] = ($urandom_range(0, 3) != 0);
        add_tag(name, flags, $urandom);
    endtask

    task automatic build_random_buffer();
        int shape;
        int cut;
        add_noise($urandom_range(0, 12), 8);
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
            add_noise($urandom_range(1, 20), 4);
        end else begin
            if (shape <= 2)
                add_broken_header();
            if (shape != 1) begin
                add_valid_header();
                case ($urandom_range(0, 5))
                    0: ;
                    1: add_random_tag(TAG_XING);
                    2: add_random_tag(TAG_INFO);
                    3: begin
                        add_random_tag(TAG_INFO);
                        add_random_tag(TAG_XING);
                    end
                    4: begin
                        add_random_tag(TAG_XING);
                        add_random_tag(TAG_INFO);
                    end
                    default: begin
                        // start the tag on the header's third or fourth byte
                        repeat ($urandom_range(1, 2)) void'(head_bytes.pop_back());
                        add_random_tag($urandom_range(0, 1) ? TAG_XING : TAG_INFO);
                    end
                endcase
                if ($urandom_range(0, 7) == 0) begin
                    cut = $urandom_range(1, 10);
                    repeat (cut)
                        if (head_bytes.size() > 1)
                            void'(head_bytes.pop_back());
                end
            end
            add_noise($urandom_range(0, 8), 8);
        end
    endtask

    task automatic run_random_phase(input logic [15:0] offset, input int quota);
        int first;
        set_search_start(offset);
        first = sent_bytes;
        while (sent_bytes - first < quota) begin
            build_random_buffer();
            send_buffer();
            if ($urandom_range(0, 9) == 0)
                drain_results();
        end
    endtask

    // Xing tag placed gap bytes after the header's first byte
    task automatic send_distant_tag(input int gap);
        add_valid_header();
        add_noise(gap - 4, 0);
        add_tag(TAG_XING, 32'h0000_000F, $urandom);
        add_noise(4, 0);
        send_buffer();
    endtask

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_search_start(16'd0);
        // lone byte, nothing found
        head_bytes.push_back(8'h00);
        send_buffer();
        add_header(VER_1, 2'd3, 4'd14, 2'd2, MODE_MONO);
        add_tag(TAG_XING, 32'h0000_0001, 32'hFFFF_FFFF);
        send_buffer();
        // lowest fields, Info with flag bit 0 clear
        add_header(VER_25, 2'd1, 4'd1, 2'd0, 2'd0);
        add_tag(TAG_INFO, 32'hFFFF_FFFE, 32'h1234_5678);
        send_buffer();
        // Xing wins even with its flag clear
        add_header(VER_2, 2'd2, 4'd9, 2'd1, 2'd1);
        add_tag(TAG_XING, 32'h0000_0000, 32'd77);
        add_tag(TAG_INFO, 32'h0000_0001, 32'd99);
        send_buffer();
        // tag begins on the header's third byte
        add_header(VER_1, 2'd1, 4'd5, 2'd2, 2'd0);
        repeat (2) void'(head_bytes.pop_back());
        add_tag(TAG_XING, 32'h0000_0001, 32'd1000);
        send_buffer();
        // frame count cut off by the buffer end
        add_valid_header();
        add_tag(TAG_INFO, 32'h0000_0001, 32'hA5A5_5A5A);
        repeat (2) void'(head_bytes.pop_back());
        send_buffer();

        set_search_start(16'hFFFF);
        add_noise(2, 0);
        add_valid_header();
        send_buffer();

        // tag fits the window exactly or runs one byte past it
        set_search_start(16'd0);
        send_distant_tag(TAG_WINDOW_DEF - 12 + $urandom_range(0, 1));

        run_random_phase(16'd0, 140);
        run_random_phase(16'($urandom_range(1, 8)), 120);
        run_random_phase(16'($urandom_range(9, 24)), 120);
        run_random_phase(16'd0, 110);
        run_random_phase(16'($urandom_range(1, 15)), 130);

        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && results_due == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/mahf_pkg.sv
rtl/mahf_hdr_decode.sv
rtl/mahf_tag_scan.sv
rtl/mpeg_audio_header_finder.sv
verif/mahf_result_checker.sv
verif/mpeg_audio_header_finder_tb.sv
